// ===== sv/qkvbp_pkg.sv =====
// ----------------------------------------------------------------------------
// qkvbp_pkg
// Shared types, character codes and helpers for the key/value block parser.
// ----------------------------------------------------------------------------
package qkvbp_pkg;

  localparam int QKVBP_FIFO_DEPTH = 4;
  localparam int MAX_EV           = 3;
  localparam int CNT_W            = $clog2(MAX_EV + 1);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [2:0] {
    EV_OPEN       = 3'd0,
    EV_KEY_BYTE   = 3'd1,
    EV_KEY_END    = 3'd2,
    EV_VAL_BYTE   = 3'd3,
    EV_VAL_END    = 3'd4,
    EV_CLOSE      = 3'd5,
    EV_CLOSE_DROP = 3'd6
  } ev_kind_t;

  typedef enum logic [2:0] {
    GR_OUT = 3'b001,
    GR_KEY = 3'b010,
    GR_VAL = 3'b100
  } gr_phase_t;

  typedef enum logic [2:0] {
    LX_GAP   = 3'b001,
    LX_QUOTE = 3'b010,
    LX_WORD  = 3'b100
  } lx_phase_t;

  // Events raised by one text byte, slot 0 first
  typedef struct packed {
    logic [CNT_W-1:0]           cnt;
    logic [MAX_EV-1:0][2:0]     kind;
    logic [MAX_EV-1:0][7:0]     data;
  } ev_bundle_t;

  typedef struct packed {
    gr_phase_t gp;
    lx_phase_t lp;
  } front_st_t;

  function automatic logic is_white(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  // Append one event; drop it once all slots are taken
  function automatic ev_bundle_t push_ev(ev_bundle_t bun, ev_kind_t k, logic [7:0] d);
    ev_bundle_t r;
    r = bun;
    if (bun.cnt != CNT_W'(MAX_EV)) begin
      r.kind[bun.cnt] = k;
      r.data[bun.cnt] = d;
      r.cnt           = bun.cnt + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== sv/qkvbp_front.sv =====
// ----------------------------------------------------------------------------
// qkvbp_front
// Lexer/block grammar: classify one accepted byte a cycle into an event bundle.
// ----------------------------------------------------------------------------
module qkvbp_front
  import qkvbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  text_byte,
  input  logic        is_final,
  output ev_bundle_t  bun,
  output front_st_t   st
);

  typedef struct packed {
    gr_phase_t  gp;
    lx_phase_t  lp;
    logic [7:0] hb;
    logic [1:0] hc;
    ev_bundle_t bun;
  } lex_t;

  gr_phase_t  gp_r, gp_nxt;
  lx_phase_t  lp_r, lp_nxt;
  logic [7:0] hb_r, hb_nxt;
  logic [1:0] hc_r, hc_nxt;

  // Close the current token in the grammar
  function automatic lex_t tok_end(lex_t s);
    lex_t r;
    r = s;
    if (s.gp == GR_KEY) begin
      r.bun = push_ev(s.bun, EV_KEY_END, 8'h00);
      r.gp  = GR_VAL;
    end else if (s.gp == GR_VAL) begin
      r.bun = push_ev(s.bun, EV_VAL_END, 8'h00);
      r.gp  = GR_KEY;
    end
    return r;
  endfunction

  function automatic lex_t tok_byte(lex_t s, logic [7:0] b);
    lex_t r;
    r = s;
    if (s.gp == GR_KEY) begin
      r.bun = push_ev(s.bun, EV_KEY_BYTE, b);
    end else if (s.gp == GR_VAL) begin
      r.bun = push_ev(s.bun, EV_VAL_BYTE, b);
    end
    return r;
  endfunction

  // End of a quoted token: resolve a held single byte against the braces
  function automatic lex_t q_end(lex_t s);
    lex_t r;
    logic single;
    r      = s;
    single = (s.hc == 2'd1);
    if (s.gp == GR_KEY) begin
      if (single && s.hb == CH_RBRACE) begin
        r.bun = push_ev(r.bun, EV_CLOSE, 8'h00);
        r.gp  = GR_OUT;
      end else begin
        if (single) r.bun = push_ev(r.bun, EV_KEY_BYTE, s.hb);
        r.bun = push_ev(r.bun, EV_KEY_END, 8'h00);
        r.gp  = GR_VAL;
      end
    end else if (s.gp == GR_VAL) begin
      r.bun = push_ev(r.bun, EV_VAL_END, 8'h00);
      r.gp  = GR_KEY;
    end else if (single && s.hb == CH_LBRACE) begin
      r.bun = push_ev(r.bun, EV_OPEN, 8'h00);
      r.gp  = GR_KEY;
    end
    r.hc = 2'd0;
    r.hb = 8'h00;
    return r;
  endfunction

  lex_t s;

  always_comb begin
    s     = '{gp: gp_r, lp: lp_r, hb: hb_r, hc: hc_r, bun: '0};
    unique case (lp_r)
      LX_GAP: begin
        priority if (is_white(text_byte)) begin
          s = s;
        end else if (text_byte == CH_LBRACE) begin
          if (gp_r != GR_OUT) begin
            s = tok_end(tok_byte(s, text_byte));
          end else begin
            s.bun = push_ev(s.bun, EV_OPEN, 8'h00);
            s.gp  = GR_KEY;
          end
        end else if (text_byte == CH_RBRACE) begin
          if (gp_r == GR_KEY) begin
            s.bun = push_ev(s.bun, EV_CLOSE, 8'h00);
            s.gp  = GR_OUT;
          end else if (gp_r == GR_VAL) begin
            s = tok_end(tok_byte(s, text_byte));
          end
        end else if (text_byte == CH_QUOTE) begin
          s.lp = LX_QUOTE;
          s.hc = 2'd0;
          s.hb = 8'h00;
        end else begin
          s.lp = LX_WORD;
          s    = tok_byte(s, text_byte);
        end
      end
      LX_QUOTE: begin
        if (text_byte == CH_QUOTE) begin
          s    = q_end(s);
          s.lp = LX_GAP;
        end else if (gp_r == GR_VAL) begin
          s.bun = push_ev(s.bun, EV_VAL_BYTE, text_byte);
        end else if (hc_r == 2'd0) begin
          s.hb = text_byte;
          s.hc = 2'd1;
        end else begin
          if (gp_r == GR_KEY) begin
            if (hc_r == 2'd1) s.bun = push_ev(s.bun, EV_KEY_BYTE, hb_r);
            s.bun = push_ev(s.bun, EV_KEY_BYTE, text_byte);
          end
          s.hc = 2'd2;
        end
      end
      default: begin
        if (is_white(text_byte)) begin
          s    = tok_end(s);
          s.lp = LX_GAP;
        end else begin
          s = tok_byte(s, text_byte);
        end
      end
    endcase

    // End of text: finish the open token, then close an open block
    if (is_final) begin
      if (s.lp != LX_GAP) begin
        if (s.gp == GR_KEY &&
            !(s.lp == LX_QUOTE && s.hc == 2'd1 && s.hb == CH_RBRACE)) begin
          if (s.lp == LX_QUOTE && s.hc == 2'd1) s.bun = push_ev(s.bun, EV_KEY_BYTE, s.hb);
          s.gp = GR_VAL;
        end else if (s.lp == LX_QUOTE) begin
          s = q_end(s);
        end else begin
          s = tok_end(s);
        end
      end
      if (s.gp == GR_KEY) begin
        s.bun = push_ev(s.bun, EV_CLOSE, 8'h00);
      end else if (s.gp == GR_VAL) begin
        s.bun = push_ev(s.bun, EV_CLOSE_DROP, 8'h00);
      end
      s.gp = GR_OUT;
      s.lp = LX_GAP;
      s.hb = 8'h00;
      s.hc = 2'd0;
    end
  end

  assign gp_nxt = acc ? s.gp : gp_r;
  assign lp_nxt = acc ? s.lp : lp_r;
  assign hb_nxt = acc ? s.hb : hb_r;
  assign hc_nxt = acc ? s.hc : hc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r <= GR_OUT;
      lp_r <= LX_GAP;
      hb_r <= 8'h00;
      hc_r <= 2'd0;
    end else begin
      gp_r <= gp_nxt;
      lp_r <= lp_nxt;
      hb_r <= hb_nxt;
      hc_r <= hc_nxt;
    end
  end

  assign bun = s.bun;
  assign st  = '{gp: gp_r, lp: lp_r};

endmodule

// ===== sv/qkvbp_fifo.sv =====
// ----------------------------------------------------------------------------
// qkvbp_fifo
// Short bundle queue between the lexer front and the event serialiser.
// ----------------------------------------------------------------------------
module qkvbp_fifo
  import qkvbp_pkg::*;
#(
  parameter int DEPTH = QKVBP_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ev_bundle_t push_data,
  output logic       ready,
  input  logic       pop,
  output logic       head_valid,
  output ev_bundle_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  ev_bundle_t       slot_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign ready      = (cnt_r != CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? bump(wp_r) : wp_r;
    rp_nxt  = pop ? bump(rp_r) : rp_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/qkvbp_back.sv =====
// ----------------------------------------------------------------------------
// qkvbp_back
// Serialise bundles into a registered stream, one event a cycle while tready.
// ----------------------------------------------------------------------------
module qkvbp_back
  import qkvbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  ev_bundle_t head,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [2:0] out_tuser,
  output logic       out_tlast
);

  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             vld_r, vld_nxt;
  logic [7:0]       data_r;
  logic [2:0]       kind_r;
  logic             last_r;
  logic             load, last;

  assign load = head_valid && (!vld_r || out_tready);
  assign last = (idx_r == CNT_W'(head.cnt - CNT_W'(1)));
  assign pop  = load && last;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      idx_nxt = last ? '0 : idx_r + CNT_W'(1);
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Payload: load with the slot under the index
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= head.kind[idx_r];
      data_r <= head.data[idx_r];
      last_r <= last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

// ===== sv/quoted_key_value_block_parser_core.sv =====
// ----------------------------------------------------------------------------
// quoted_key_value_block_parser_core
// Quoted key/value block tokenizer: text bytes in, block/key/value events out.
// ----------------------------------------------------------------------------
// Usage
//   Input stream: one text byte per transfer on in_tdata, in_tlast high on
//   the last byte of a text. Output stream: one event per transfer, kind on
//   out_tuser, key or value byte on out_tdata (zero for other kinds),
//   out_tlast high on the last event raised by one input byte. A byte that
//   raises no event produces no output transfer.
//   The first event of a byte is written into a queue slot, then loaded
//   into the output register. One byte per cycle is taken while each byte
//   raises at most one event and out_tready is high; the output port moves
//   one event per cycle while out_tready is high, one transfer for each of
//   a byte's events. The lexer/grammar state updates once per accepted byte.
//   A queue of FIFO_DEPTH event bundles decouples the lexer from the
//   serialiser: when the receiver stalls, the queue fills, and in_tready
//   drops only once it is full.
//   Reset (rst_n low, synchronous) returns to outside any block, between
//   tokens, and empties the queue. After a byte with in_tlast the parser
//   state returns to the same reset state.
// ----------------------------------------------------------------------------
module quoted_key_value_block_parser_core
  import qkvbp_pkg::*;
#(
  parameter int FIFO_DEPTH = QKVBP_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,   // is_final
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] event_byte
  output logic [2:0] out_tuser,  // [2:0] event_kind
  output logic       out_tlast   // last_of_run
);

  logic       in_acc;
  ev_bundle_t bun;
  front_st_t  st;
  logic       q_push, q_ready, q_pop, q_valid;
  ev_bundle_t q_head;

  // Take a byte whenever the queue has room for its bundle
  assign in_tready = q_ready;
  assign in_acc    = in_tvalid && in_tready;
  // Drop empty bundles: silent bytes raise no output transfer
  assign q_push    = in_acc && (bun.cnt != '0);

  qkvbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .text_byte (in_tdata),
    .is_final  (in_tlast),
    .bun       (bun),
    .st        (st)
  );

  qkvbp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (bun),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  qkvbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // End of text leaves the parser in its reset state
  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> st.gp == GR_OUT && st.lp == LX_GAP)
    else $error("parser state not cleared after final byte");

  // Only key and value byte events carry a byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_KEY_BYTE && out_tuser != EV_VAL_BYTE
    |-> out_tdata == 8'h00)
    else $error("non-byte event carries data");

  // No event kind beyond close-dropping-key
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 3'd7)
    else $error("invalid event kind");

  // A pushed bundle never exceeds the slot count
  a_bundle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> bun.cnt <= CNT_W'(MAX_EV))
    else $error("event bundle overflow");

endmodule
